// ===== hw/rtl/lcd_shadow_diff_refresh_defines.svh =====
// Assertion macros shared by the RTL of the shadow-buffer refresh block.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef LCD_SHADOW_DIFF_REFRESH_DEFINES_SVH
`define LCD_SHADOW_DIFF_REFRESH_DEFINES_SVH

`ifndef ASSERT_OFF

// The property prop must hold at every clock edge outside reset.
`define LCDSD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// If ante holds at an edge, then cons must hold at the next edge.
`define LCDSD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define LCDSD_ASSERT(lbl, prop, msg)
`define LCDSD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/lcdsd_pkg.sv =====
`default_nettype none

package lcdsd_pkg;

	localparam int COLS       = 20;
	localparam int ROWS       = 4;
	localparam int CELLS      = COLS * ROWS;
	localparam int ADDR_W     = $clog2(CELLS);
	localparam int COL_W      = 5;
	localparam int LINE_W     = 3;
	localparam int OUT_LINE_W = 2;
	localparam int CHAR_W     = 8;

	localparam logic OP_WRITE   = 1'b0;
	localparam logic OP_REFRESH = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_FLUSH
	} state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lcdsd_ram.sv =====
`default_nettype none

module lcdsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 80
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/lcd_shadow_diff_refresh.sv =====
`default_nettype none
// Character display frame store with a shadow of what the panel shows.
// Commands are taken when start is high and busy is low. A write command
// (operation 0) stores char_code at column/line and leaves
// busy low; writes outside the 20 x 4 grid are dropped. A refresh command
// (operation 1) scans the given row, one cell per cycle through the frame
// and shadow memories, and reports every cell whose frame code differs from
// the shadow, updating the shadow as it goes.
// Each changed cell appears on out_column/out_line/out_char for one cycle
// with strobe high; move_cursor marks a cell that does not directly follow
// the previous reported one, and last marks the final cell of the scan.
// During a refresh busy stays high through one memory read per column,
// then the ST_LAST state for the last compare and the ST_FLUSH state
// to release the held final result. A refresh of a row outside the grid
// or of an unchanged row gives no results. Results are at most one a cycle
// and the receiver must take each one as it appears. Reset clears both
// stores at once through per-cell valid flags, so the block is ready
// straight after reset is released.
`include "lcd_shadow_diff_refresh_defines.svh"

module lcd_shadow_diff_refresh
	import lcdsd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic                  operation,
	input  wire logic [COL_W-1:0]      column,
	input  wire logic [LINE_W-1:0]     line,
	input  wire logic [CHAR_W-1:0]     char_code,
	output logic                       strobe,
	output logic      [COL_W-1:0]      out_column,
	output logic      [OUT_LINE_W-1:0] out_line,
	output logic      [CHAR_W-1:0]     out_char,
	output logic                       move_cursor,
	output logic                       last
);

	state_t state_q, state_d;

	logic              accept;
	logic              wr_frame;
	logic              start_scan;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;

	logic [CELLS-1:0]  frame_vld_q;
	logic [CELLS-1:0]  shown_vld_q;

	logic [ADDR_W-1:0]     base_q;
	logic [OUT_LINE_W-1:0] line_q;
	logic [COL_W-1:0]      col_q;

	logic              active_s1;
	logic [COL_W-1:0]  col_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              frame_vld_s1;
	logic              shown_vld_s1;

	logic [CHAR_W-1:0] frame_rd;
	logic [CHAR_W-1:0] shown_rd;
	logic [CHAR_W-1:0] frame_val;
	logic [CHAR_W-1:0] shown_val;
	logic              hit;
	logic              new_move;

	logic              have_prev_q;
	logic [COL_W:0]    next_col_q;

	logic              pend_q;
	logic [COL_W-1:0]  pend_col_q;
	logic [CHAR_W-1:0] pend_char_q;
	logic              pend_move_q;

	logic              emit_mid;
	logic              emit_end;

	logic              strobe_q;
	logic [COL_W-1:0]  out_column_q;
	logic [CHAR_W-1:0] out_char_q;
	logic              move_cursor_q;
	logic              last_q;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign wr_frame   = accept && (operation == OP_WRITE)
		&& (32'(column) < COLS) && (32'(line) < ROWS);
	assign start_scan = accept && (operation == OP_REFRESH) && (32'(line) < ROWS);

	assign wr_addr = ADDR_W'(32'(line) * COLS + 32'(column));
	assign rd_addr = base_q + ADDR_W'(col_q);

	lcdsd_ram #(.WIDTH(CHAR_W), .DEPTH(CELLS)) u_frame_ram (
		.clk   (clk),
		.we    (wr_frame),
		.waddr (wr_addr),
		.wdata (char_code),
		.raddr (rd_addr),
		.rdata (frame_rd)
	);

	lcdsd_ram #(.WIDTH(CHAR_W), .DEPTH(CELLS)) u_shown_ram (
		.clk   (clk),
		.we    (hit),
		.waddr (addr_s1),
		.wdata (frame_val),
		.raddr (rd_addr),
		.rdata (shown_rd)
	);

	// A cell never written since reset reads as zero.
	assign frame_val = frame_vld_s1 ? frame_rd : '0;
	assign shown_val = shown_vld_s1 ? shown_rd : '0;
	assign hit       = active_s1 && (frame_val != shown_val);
	assign new_move  = !have_prev_q || (next_col_q != {1'b0, col_s1});

	// The newest changed cell is held back until it is known whether another
	// follows, so that last can be set on it.
	assign emit_mid = hit && pend_q;
	assign emit_end = (state_q == ST_FLUSH) && pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start_scan) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (col_q == COL_W'(COLS - 1)) begin
					state_d = ST_LAST;
				end
			end
			ST_LAST: begin
				state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_vld_q <= '0;
			shown_vld_q <= '0;
			active_s1   <= 1'b0;
			have_prev_q <= 1'b0;
			pend_q      <= 1'b0;
			strobe_q    <= 1'b0;
		end else begin
			if (wr_frame) begin
				frame_vld_q[wr_addr] <= 1'b1;
			end
			if (hit) begin
				shown_vld_q[addr_s1] <= 1'b1;
			end
			active_s1 <= (state_q == ST_SCAN);
			if (start_scan) begin
				have_prev_q <= 1'b0;
			end else if (hit) begin
				have_prev_q <= 1'b1;
			end
			if (hit) begin
				pend_q <= 1'b1;
			end else if (state_q == ST_FLUSH) begin
				pend_q <= 1'b0;
			end
			strobe_q <= emit_mid || emit_end;
		end
	end

	always_ff @(posedge clk) begin
		if (start_scan) begin
			base_q <= wr_addr - ADDR_W'(column);
			line_q <= line[OUT_LINE_W-1:0];
			col_q  <= '0;
		end else if (state_q == ST_SCAN) begin
			col_q <= col_q + COL_W'(1);
		end
		col_s1       <= col_q;
		addr_s1      <= rd_addr;
		frame_vld_s1 <= frame_vld_q[rd_addr];
		shown_vld_s1 <= shown_vld_q[rd_addr];
		if (hit) begin
			next_col_q  <= {1'b0, col_s1} + (COL_W + 1)'(1);
			pend_col_q  <= col_s1;
			pend_char_q <= frame_val;
			pend_move_q <= new_move;
		end
		if (emit_mid || emit_end) begin
			out_column_q  <= pend_col_q;
			out_char_q    <= pend_char_q;
			move_cursor_q <= pend_move_q;
			last_q        <= emit_end;
		end
	end

	assign strobe      = strobe_q;
	assign out_column  = out_column_q;
	assign out_line    = line_q;
	assign out_char    = out_char_q;
	assign move_cursor = move_cursor_q;
	assign last        = last_q;

	`LCDSD_ASSERT_NEXT(a_write_single_cycle, start && !busy && (operation == OP_WRITE), !busy, "write command raised busy")
	`LCDSD_ASSERT(a_more_after_not_last, !(strobe && !last) || busy, "scan ended without a last result")
	`LCDSD_ASSERT(a_idle_no_pending, (state_q != ST_IDLE) || !pend_q, "result left pending in idle")
	`LCDSD_ASSERT(a_column_in_grid, !strobe || (32'(out_column) < COLS), "result column outside grid")

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`default_nettype none

module tb_top;
	import lcdsd_pkg::*;

	localparam int PERIOD      = 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE      = COLS + 4;
	localparam int DRAIN_LIMIT = 2000;
	localparam int PHASE_CMDS  = 64;
	localparam int DIR_ROWS    = 25;
	localparam int HAND_CELLS  = 5;

	typedef struct packed {
		logic                op;
		logic [COL_W-1:0]    col;
		logic [LINE_W-1:0]   ln;
		logic [CHAR_W-1:0]   chr;
	} cmd_t;

	typedef struct packed {
		logic [COL_W-1:0]      col;
		logic [OUT_LINE_W-1:0] ln;
		logic [CHAR_W-1:0]     chr;
		logic                  move;
		logic                  fin;
	} cell_result_t;

	// hand_n is the number of changed cells typed in below, or -1 to use the predictor.
	typedef struct packed {
		cmd_t cmd;
		int   hand_n;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic                  operation = OP_WRITE;
	logic [COL_W-1:0]      column = '0;
	logic [LINE_W-1:0]     line = '0;
	logic [CHAR_W-1:0]     char_code = '0;
	logic                  strobe;
	logic [COL_W-1:0]      out_column;
	logic [OUT_LINE_W-1:0] out_line;
	logic [CHAR_W-1:0]     out_char;
	logic                  move_cursor;
	logic                  last;

	logic [CHAR_W-1:0] frame_mem [CELLS];
	logic [CHAR_W-1:0] shown_mem [CELLS];
	cell_result_t      cells_due [$];
	cell_result_t      scan_cells [$];

	int error_count = 0;
	int cells_seen = 0;
	int cmds_sent = 0;
	int refreshes_sent = 0;
	int useful_cmds = 0;
	int widest_scan = 0;
	int cycle_count = 0;
	int idle_pct = 0;
	int typed_pos = 0;

	dir_row_t directed_rows [DIR_ROWS] = '{
		'{'{OP_REFRESH, 5'd0,  3'd0, 8'h00}, 0},
		'{'{OP_REFRESH, 5'd0,  3'd3, 8'h00}, 0},
		'{'{OP_WRITE,   5'd0,  3'd0, 8'hFF}, 0},
		'{'{OP_WRITE,   5'd19, 3'd0, 8'h01}, 0},
		'{'{OP_REFRESH, 5'd0,  3'd0, 8'h00}, 2},
		'{'{OP_REFRESH, 5'd0,  3'd0, 8'h00}, 0},
		'{'{OP_WRITE,   5'd20, 3'd0, 8'hAA}, 0},
		'{'{OP_WRITE,   5'd31, 3'd7, 8'h55}, 0},
		'{'{OP_WRITE,   5'd5,  3'd4, 8'h77}, 0},
		'{'{OP_REFRESH, 5'd0,  3'd0, 8'h00}, 0},
		'{'{OP_REFRESH, 5'd31, 3'd7, 8'hFF}, 0},
		'{'{OP_REFRESH, 5'd0,  3'd4, 8'h00}, 0},
		'{'{OP_WRITE,   5'd3,  3'd3, 8'h80}, 0},
		'{'{OP_WRITE,   5'd4,  3'd3, 8'h7F}, 0},
		'{'{OP_WRITE,   5'd6,  3'd3, 8'h2A}, 0},
		'{'{OP_REFRESH, 5'd0,  3'd3, 8'h00}, 3},
		'{'{OP_WRITE,   5'd3,  3'd3, 8'h80}, 0},
		'{'{OP_WRITE,   5'd1,  3'd1, 8'h33}, 0},
		'{'{OP_WRITE,   5'd1,  3'd1, 8'h00}, 0},
		'{'{OP_REFRESH, 5'd0,  3'd1, 8'h00}, 0},
		'{'{OP_WRITE,   5'd0,  3'd2, 8'h41}, 0},
		'{'{OP_WRITE,   5'd1,  3'd2, 8'h42}, 0},
		'{'{OP_WRITE,   5'd19, 3'd2, 8'hFF}, 0},
		'{'{OP_REFRESH, 5'd0,  3'd2, 8'h00}, -1},
		'{'{OP_REFRESH, 5'd0,  3'd3, 8'h00}, 0}
	};

	cell_result_t typed_cells [HAND_CELLS] = '{
		'{5'd0,  2'd0, 8'hFF, 1'b1, 1'b0},
		'{5'd19, 2'd0, 8'h01, 1'b1, 1'b1},
		'{5'd3,  2'd3, 8'h80, 1'b1, 1'b0},
		'{5'd4,  2'd3, 8'h7F, 1'b0, 1'b0},
		'{5'd6,  2'd3, 8'h2A, 1'b1, 1'b1}
	};

	lcd_shadow_diff_refresh DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.operation   (operation),
		.column      (column),
		.line        (line),
		.char_code   (char_code),
		.strobe      (strobe),
		.out_column  (out_column),
		.out_line    (out_line),
		.out_char    (out_char),
		.move_cursor (move_cursor),
		.last        (last)
	);

	always #(PERIOD / 2) clk = ~clk;

	task automatic flag_mismatch(input string what);
		$display("MISMATCH at cycle %0d: %s", cycle_count, what);
		error_count++;
	endtask

	// Applies one command to the model of both stores and lists the changed cells it sends.
	task automatic apply_to_frame(input cmd_t c);
		int idx;
		int next_col;
		cell_result_t found;
		scan_cells.delete();
		if (c.op == OP_WRITE) begin
			if (c.col < COLS && c.ln < ROWS) begin
				frame_mem[c.ln * COLS + c.col] = c.chr;
				useful_cmds++;
			end
		end else if (c.ln < ROWS) begin
			useful_cmds++;
			next_col = -1;
			for (int k = 0; k < COLS; k++) begin
				idx = c.ln * COLS + k;
				if (frame_mem[idx] != shown_mem[idx]) begin
					found.col = COL_W'(k);
					found.ln = OUT_LINE_W'(c.ln);
					found.chr = frame_mem[idx];
					found.move = (next_col != k);
					found.fin = 1'b0;
					scan_cells.push_back(found);
					shown_mem[idx] = frame_mem[idx];
					next_col = k + 1;
				end
			end
			if (scan_cells.size() > 0)
				scan_cells[scan_cells.size() - 1].fin = 1'b1;
			if (scan_cells.size() > widest_scan)
				widest_scan = scan_cells.size();
		end
	endtask

	// Presents one command and holds it until the transfer; the sender drops start at random.
	task automatic issue(input cmd_t c, input int hand_n);
		bit taken;
		taken = 1'b0;
		operation <= c.op;
		column <= c.col;
		line <= c.ln;
		char_code <= c.chr;
		start <= (idle_pct == 0) || ($urandom_range(0, 99) >= idle_pct);
		while (!taken) begin
			@(posedge clk);
			if (start && !busy)
				taken = 1'b1;
			else
				start <= (idle_pct == 0) || ($urandom_range(0, 99) >= idle_pct);
		end
		cmds_sent++;
		if (c.op == OP_REFRESH)
			refreshes_sent++;
		apply_to_frame(c);
		if (hand_n < 0) begin
			foreach (scan_cells[k])
				cells_due.push_back(scan_cells[k]);
		end else begin
			for (int k = 0; k < hand_n; k++) begin
				cells_due.push_back(typed_cells[typed_pos]);
				typed_pos++;
			end
		end
	endtask

	task automatic settle();
		start <= 1'b0;
		for (int i = 0; i < DRAIN_LIMIT && cells_due.size() != 0; i++)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Writes into one row, then refreshes it. Roughly a quarter of the writes
	// store the value already in the cell, so some scans find nothing new.
	task automatic row_burst(input int n, input bit contiguous, input bit full_row);
		int r;
		int base;
		int col;
		cmd_t c;
		r = $urandom_range(0, ROWS - 1);
		base = $urandom_range(0, COLS - 1);
		for (int k = 0; k < (full_row ? COLS : n); k++) begin
			if (full_row)
				col = k;
			else if (contiguous)
				col = (base + k) % COLS;
			else
				col = $urandom_range(0, COLS - 1);
			c.op = OP_WRITE;
			c.col = COL_W'(col);
			c.ln = LINE_W'(r);
			if ($urandom_range(0, 3) == 0)
				c.chr = frame_mem[r * COLS + col];
			else
				c.chr = CHAR_W'($urandom_range(0, 255));
			issue(c, -1);
		end
		c.op = OP_REFRESH;
		c.col = COL_W'($urandom_range(0, 31));
		c.ln = LINE_W'(r);
		c.chr = CHAR_W'($urandom_range(0, 255));
		issue(c, -1);
	endtask

	// Writes that fall outside the grid, followed by a refresh of any row.
	task automatic broken_burst();
		cmd_t c;
		for (int k = 0; k < $urandom_range(1, 3); k++) begin
			c.op = OP_WRITE;
			c.chr = CHAR_W'($urandom_range(0, 255));
			if ($urandom_range(0, 1)) begin
				c.col = COL_W'($urandom_range(COLS, 31));
				c.ln = LINE_W'($urandom_range(0, 7));
			end else begin
				c.col = COL_W'($urandom_range(0, 31));
				c.ln = LINE_W'($urandom_range(ROWS, 7));
			end
			issue(c, -1);
		end
		c.op = OP_REFRESH;
		c.col = COL_W'($urandom_range(0, 31));
		c.ln = LINE_W'($urandom_range(0, 7));
		c.chr = CHAR_W'($urandom_range(0, 255));
		issue(c, -1);
	endtask

	always @(posedge clk) begin : result_check
		cell_result_t want;
		if (arst_n && strobe === 1'b1) begin
			if (cells_due.size() == 0) begin
				flag_mismatch($sformatf("cell col %0d line %0d sent with nothing expected",
					out_column, out_line));
			end else begin
				want = cells_due.pop_front();
				cells_seen++;
				if (out_column !== want.col)
					flag_mismatch($sformatf("out_column %0d, expected %0d", out_column, want.col));
				if (out_line !== want.ln)
					flag_mismatch($sformatf("out_line %0d, expected %0d", out_line, want.ln));
				if (out_char !== want.chr)
					flag_mismatch($sformatf("out_char %02h, expected %02h", out_char, want.chr));
				if (move_cursor !== want.move)
					flag_mismatch($sformatf("move_cursor %b, expected %b at col %0d",
						move_cursor, want.move, want.col));
				if (last !== want.fin)
					flag_mismatch($sformatf("last %b, expected %b at col %0d",
						last, want.fin, want.col));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// The receiver cannot hold results off, so the phases meant to stall it
	// only keep whatever the sender does.
	int idle_plan [4] = '{0, 49, 0, 37};

	initial begin
		cmd_t c;
		int pick;
		foreach (frame_mem[i]) begin
			frame_mem[i] = '0;
			shown_mem[i] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			issue(directed_rows[i].cmd, directed_rows[i].hand_n);
		settle();

		foreach (idle_plan[p]) begin
			idle_pct = idle_plan[p];
			useful_cmds = 0;
			// One full row per phase writes every cell of a row and then refreshes it.
			row_burst(COLS, 1'b0, 1'b1);
			while (useful_cmds < PHASE_CMDS) begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					row_burst($urandom_range(1, 6), $urandom_range(0, 1), 1'b0);
				end else if (pick < 85) begin
					c.op = $urandom_range(0, 1) ? OP_REFRESH : OP_WRITE;
					c.col = COL_W'($urandom_range(0, 31));
					c.ln = LINE_W'($urandom_range(0, 7));
					c.chr = CHAR_W'($urandom_range(0, 255));
					issue(c, -1);
				end else begin
					broken_burst();
				end
				if ($urandom_range(0, 19) == 0)
					settle();
			end
			settle();
		end

		if (cells_due.size() != 0)
			flag_mismatch($sformatf("%0d changed cells never sent", cells_due.size()));
		$display("Drove %0d commands (%0d row refreshes) across four idling phases.",
			cmds_sent, refreshes_sent);
		$display("Checked %0d changed cells; the widest scan sent %0d.", cells_seen, widest_scan);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== lcd_shadow_diff_refresh.f =====
+incdir+hw/rtl
hw/rtl/lcdsd_pkg.sv
hw/rtl/lcdsd_ram.sv
hw/rtl/lcd_shadow_diff_refresh.sv
sim/tb_top.sv
